// ===== hw/rtl/refcounted_page_allocator_defines.svh =====
// Assertion macros for the reference counted page allocator.
// Included by the top level; needs no other file.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define RPA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page allocator check failed");
// Next-cycle implication, disabled while reset is high.
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page allocator check failed");
`else
`define RPA_ASSERT_NOW(label, clk, rst, ante, cons)
`define RPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/rpa_pkg.sv =====
// Shared types and constants of the reference counted page allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package rpa_pkg;

  localparam int ADDR_W      = 40;
  localparam int ACT_W       = 3;
  localparam int ST_W        = 3;
  localparam int CNT_W       = 16;
  localparam int FREE_W      = 11;
  localparam int WAIT_W      = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;

  // Action codes on the input tuser.
  localparam logic [ACT_W-1:0] ACT_ALLOC     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FREE      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FORCE     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SHARE_ADD = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SHARE_SUB = 3'd4;

  // Status codes on the output tuser.
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_SHARED   = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_USED = 3'd4;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sweep;   // initialize one entry of both memories
    logic accept;  // latch the input transfer and issue the memory reads
    logic commit;  // write back and load the result register
  } rpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;
  } rpa_stat_t;

endpackage

// ===== hw/rtl/rpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the free ring and the share count store.
module rpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/rpa_ctrl.sv =====
// Controller of the page allocator: init sweep, accept and commit sequencing,
// and the output valid flag. Depends on rpa_pkg.
module rpa_ctrl
  import rpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_valid,
  output logic      s_ready,
  output logic      m_valid,
  input  logic      m_ready,
  output rpa_cmd_t  cmd,
  input  rpa_stat_t stat
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign s_ready    = (state == S_IDLE);
  assign cmd.sweep  = (state == S_INIT);
  assign cmd.accept = s_ready && s_valid;
  // The result register may be loaded once it is empty or being drained.
  assign cmd.commit = (state == S_EXEC) && (!m_valid || m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      m_valid <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          if (stat.sweep_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
      if (cmd.commit) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/rpa_datapath.sv =====
// Datapath of the page allocator: address decode, free ring, share counts,
// waiter count and the result register. Depends on rpa_pkg and rpa_ram.
module rpa_datapath
  import rpa_pkg::*;
#(
  parameter int POOL_PAGES = 1024,
  parameter int PAGE_BITS  = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [ACT_W-1:0]       s_tuser,
  input  rpa_cmd_t               cmd,
  output rpa_stat_t              stat,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [ST_W-1:0]        m_tuser
);

  localparam int IW    = $clog2(POOL_PAGES);
  localparam int TW    = $clog2(POOL_PAGES + 1);
  localparam int OFF_W = ADDR_W - PAGE_BITS;
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_PAGES - 1);
  localparam logic [TW-1:0] TOTAL_RST = TW'(POOL_PAGES);

  // Control-side state.
  logic [ADDR_W-1:0] pool_base;
  logic [IW-1:0]     head;
  logic [TW-1:0]     total;
  logic [WAIT_W-1:0] waiting;
  logic [IW-1:0]     sweep_idx;

  // Latched item.
  logic [ACT_W-1:0]  act_r;
  logic [IW-1:0]     idx_r;
  logic              ok_r;

  // Address decode of the incoming item.
  logic [ADDR_W-1:0] addr_in;
  logic [ADDR_W-1:0] diff;
  logic [OFF_W-1:0]  off;
  logic              in_range;
  logic [IW-1:0]     idx_in;

  assign addr_in  = s_tdata[ADDR_W-1:0];
  assign diff     = addr_in - pool_base;
  assign off      = diff[ADDR_W-1:PAGE_BITS];
  assign in_range = (addr_in >= pool_base) && (off < OFF_W'(POOL_PAGES));
  assign idx_in   = off[IW-1:0];

  // Memory ports.
  logic [IW-1:0]    ord_rd;
  logic [CNT_W-1:0] cnt_rd;
  logic             ow_en;
  logic [IW-1:0]    ow_addr;
  logic             cw_en;
  logic [IW-1:0]    cw_addr;
  logic [CNT_W-1:0] cw_data;

  rpa_ram #(.WIDTH(IW), .DEPTH(POOL_PAGES)) u_order_ram (
    .clk  (clk),
    .we   (cmd.sweep || (cmd.commit && ow_en)),
    .waddr(cmd.sweep ? sweep_idx : ow_addr),
    .wdata(cmd.sweep ? sweep_idx : idx_r),
    .re   (cmd.accept),
    .raddr(head),
    .rdata(ord_rd)
  );

  rpa_ram #(.WIDTH(CNT_W), .DEPTH(POOL_PAGES)) u_count_ram (
    .clk  (clk),
    .we   (cmd.sweep || (cmd.commit && cw_en)),
    .waddr(cmd.sweep ? sweep_idx : cw_addr),
    .wdata(cmd.sweep ? '0 : cw_data),
    .re   (cmd.accept),
    .raddr(idx_in),
    .rdata(cnt_rd)
  );

  assign stat.sweep_done = (sweep_idx == LAST_IDX);

  // Helper values for the commit cycle.
  logic [IW-1:0]     alloc_idx;
  logic [ADDR_W-1:0] alloc_top;
  logic [IW-1:0]     head_inc;
  logic [IW-1:0]     head_dec;
  logic [TW:0]       tail_sum;
  logic [IW-1:0]     tail;
  logic              ring_room;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cnt_add;
  logic [CNT_W-1:0]  cnt_sub;

  assign alloc_idx = ((IW + 1)'(ord_rd) >= (IW + 1)'(POOL_PAGES)) ? '0 : ord_rd;
  assign alloc_top = pool_base + ((ADDR_W'(alloc_idx) + ADDR_W'(1)) << PAGE_BITS);
  assign head_inc  = (head == LAST_IDX) ? '0 : head + IW'(1);
  assign head_dec  = (head == '0) ? LAST_IDX : head - IW'(1);
  assign tail_sum  = (TW + 1)'(head) + (TW + 1)'(total);
  assign tail      = (tail_sum >= (TW + 1)'(POOL_PAGES)) ?
                     IW'(tail_sum - (TW + 1)'(POOL_PAGES)) : IW'(tail_sum);
  assign ring_room = (total < TOTAL_RST);
  assign cnt_dec   = cnt_rd - CNT_W'(1);
  assign cnt_add   = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + CNT_W'(1);
  assign cnt_sub   = (cnt_rd > CNT_W'(1)) ? cnt_dec : cnt_rd;

  logic [ST_W-1:0]   st_n;
  logic [ADDR_W-1:0] top_n;
  logic [CNT_W-1:0]  cnt_n;
  logic [IW-1:0]     head_next;
  logic [TW-1:0]     total_next;
  logic [WAIT_W-1:0] waiting_next;
  logic              release_pg;
  logic              wake_n;

  always_comb begin
    st_n         = ST_OK;
    top_n        = '0;
    cnt_n        = '0;
    head_next    = head;
    total_next   = total;
    waiting_next = waiting;
    release_pg   = 1'b0;
    wake_n       = 1'b0;
    ow_en        = 1'b0;
    ow_addr      = head;
    cw_en        = 1'b0;
    cw_addr      = idx_r;
    cw_data      = '0;
    unique case (act_r)
      ACT_ALLOC: begin
        if (total == '0) begin
          st_n = ST_EMPTY;
          if (waiting != WAIT_MAX) begin
            waiting_next = waiting + WAIT_W'(1);
          end
        end else begin
          head_next  = head_inc;
          total_next = total - TW'(1);
          cw_en      = 1'b1;
          cw_addr    = alloc_idx;
          cw_data    = CNT_W'(1);
          cnt_n      = CNT_W'(1);
          top_n      = alloc_top;
        end
      end
      ACT_FREE, ACT_FORCE, ACT_SHARE_ADD, ACT_SHARE_SUB: begin
        if (!ok_r) begin
          st_n = ST_RANGE;
        end else if (cnt_rd == '0) begin
          st_n = ST_NOT_USED;
        end else begin
          cw_en = 1'b1;
          unique case (act_r)
            ACT_FREE: begin
              cw_data = cnt_dec;
              cnt_n   = cnt_dec;
              if (cnt_dec != '0) begin
                st_n = ST_SHARED;
              end else if (ring_room) begin
                head_next  = head_dec;
                ow_en      = 1'b1;
                ow_addr    = head_dec;
                total_next = total + TW'(1);
                release_pg = 1'b1;
              end
            end
            ACT_FORCE: begin
              cw_data = '0;
              if (ring_room) begin
                ow_en      = 1'b1;
                ow_addr    = tail;
                total_next = total + TW'(1);
                release_pg = 1'b1;
              end
            end
            ACT_SHARE_ADD: begin
              cw_data = cnt_add;
              cnt_n   = cnt_add;
            end
            default: begin
              cw_data = cnt_sub;
              cnt_n   = cnt_sub;
            end
          endcase
        end
      end
      default: ;
    endcase
    if (release_pg && (waiting != '0)) begin
      wake_n       = 1'b1;
      waiting_next = waiting - WAIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      head      <= '0;
      total     <= TOTAL_RST;
      waiting   <= '0;
      sweep_idx <= '0;
    end else begin
      if (cfg_write) begin
        pool_base <= cfg_data;
      end
      if (cmd.sweep) begin
        sweep_idx <= sweep_idx + IW'(1);
      end
      if (cmd.commit) begin
        head    <= head_next;
        total   <= total_next;
        waiting <= waiting_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r <= s_tuser;
      idx_r <= idx_in;
      ok_r  <= in_range;
    end
    if (cmd.commit) begin
      m_tuser <= st_n;
      m_tdata <= {4'd0, wake_n, FREE_W'(total_next), cnt_n, top_n};
    end
  end

endmodule

// ===== hw/rtl/refcounted_page_allocator.sv =====
// Top level of the reference counted page allocator.
// Depends on rpa_pkg, rpa_ctrl, rpa_datapath and the assertion header.
//
// Usage: one action enters per transfer on the s_axis channel (tuser holds
// the action, tdata the page address) and gives exactly one result on the
// m_axis channel (tuser holds the status, tdata the allocated top address,
// the share count, the free page count and the wake flag). The user must
// set pool_base through cfg_write/cfg_data only while no action is in
// flight; the block does not enforce this. Flow: the accept step latches
// the item and reads the free ring and the share count memory; the commit
// step writes them back and loads the result register once it is free. A
// new action is taken only after the last one is committed. Reset: the
// free ring and the share counts are initialized by a sweep, one entry per
// cycle, with s_axis_tready low; the configuration port works during it.
// Stall: a result waits in the output register while m_axis_tready is low;
// the next input is still taken and processed, and then holds until the
// output register is free.
`include "refcounted_page_allocator_defines.svh"

module refcounted_page_allocator
  import rpa_pkg::*;
#(
  parameter int POOL_PAGES = 1024,
  parameter int PAGE_BITS  = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // page_address
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [ACT_W-1:0]       s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // alloc_top [39:0], share_count [55:40], free_pages [66:56],
  // wake_waiter [67], zero [71:68]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [ST_W-1:0]        m_axis_tuser
);

  rpa_cmd_t  cmd;
  rpa_stat_t stat;
  logic      out_empty;
  logic      out_empty_clean;

  rpa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .s_valid(s_axis_tvalid),
    .s_ready(s_axis_tready),
    .m_valid(m_axis_tvalid),
    .m_ready(m_axis_tready),
    .cmd    (cmd),
    .stat   (stat)
  );

  rpa_datapath #(
    .POOL_PAGES(POOL_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser)
  );

  assign out_empty       = m_axis_tvalid && (m_axis_tuser == ST_EMPTY);
  assign out_empty_clean = (m_axis_tdata[ADDR_W-1:0] == '0) &&
                           !m_axis_tdata[ADDR_W+CNT_W+FREE_W];

  `RPA_ASSERT_NOW(a_no_accept_in_sweep, clk, rst, cmd.sweep, !s_axis_tready)
  `RPA_ASSERT_NEXT(a_one_item_at_a_time, clk, rst, cmd.accept, !s_axis_tready)
  `RPA_ASSERT_NEXT(a_commit_gives_result, clk, rst, cmd.commit, m_axis_tvalid)
  `RPA_ASSERT_NOW(a_empty_result_clean, clk, rst, out_empty, out_empty_clean)

endmodule

// ===== test/refcounted_page_allocator_checker.sv =====
// Checker for the reference counted page allocator: keeps its own copy of the
// free ring, the share counts and the waiter count, and compares every result.
// Depends on rpa_pkg for field widths, action codes and status codes.
module refcounted_page_allocator_checker
  import rpa_pkg::*;
#(
  parameter int POOL_PAGES = 1024,
  parameter int PAGE_BITS  = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [ADDR_W-1:0]      cfg_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [ACT_W-1:0]       s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [ST_W-1:0]        m_axis_tuser,
  output int                     errors,
  output int                     outstanding
);

  localparam int IDX_W   = $clog2(POOL_PAGES);
  localparam int CNT_LO  = ADDR_W;
  localparam int FREE_LO = CNT_LO + CNT_W;
  localparam int WAKE_AT = FREE_LO + FREE_W;
  localparam int PAD_LO  = WAKE_AT + 1;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] top;
    logic [CNT_W-1:0]  count;
    logic [FREE_W-1:0] free_pages;
    logic              wake;
  } page_result_t;

  logic [IDX_W-1:0]  free_ring [POOL_PAGES];
  logic [IDX_W-1:0]  ring_front;
  logic [FREE_W-1:0] pages_free;
  logic [CNT_W-1:0]  share_of [POOL_PAGES];
  logic [WAIT_W-1:0] waiters;
  logic [ADDR_W-1:0] base_addr;
  page_result_t      results_due [$];

  function automatic logic [IDX_W-1:0] ring_slot(input int pos);
    return IDX_W'(pos % POOL_PAGES);
  endfunction

  // Puts a released page back into the ring, at the front or at the back,
  // and wakes one waiter if any is counted.
  task automatic return_page(input logic [IDX_W-1:0] idx, input bit at_front,
                             output logic woke);
    woke = 1'b0;
    if (pages_free < POOL_PAGES) begin
      if (at_front) begin
        ring_front = ring_slot(int'(ring_front) + POOL_PAGES - 1);
        free_ring[ring_front] = idx;
      end else begin
        free_ring[ring_slot(int'(ring_front) + int'(pages_free))] = idx;
      end
      pages_free++;
      if (waiters != 0) begin
        waiters--;
        woke = 1'b1;
      end
    end
  endtask

  task automatic apply_page_action(input logic [ACT_W-1:0] act,
                                   input logic [ADDR_W-1:0] addr,
                                   output page_result_t res);
    logic [ADDR_W-1:0] page_off;
    logic [ADDR_W-1:0] wide_idx;
    logic [IDX_W-1:0]  idx;
    bit                in_pool;
    res = '0;
    page_off = (addr - base_addr) >> PAGE_BITS;
    in_pool = (addr >= base_addr) && (page_off < POOL_PAGES);
    idx = page_off[IDX_W-1:0];
    if (act == ACT_ALLOC) begin
      if (pages_free == 0) begin
        res.status = ST_EMPTY;
        if (waiters != WAIT_MAX) waiters++;
      end else begin
        idx = free_ring[ring_front];
        ring_front = ring_slot(int'(ring_front) + 1);
        pages_free--;
        share_of[idx] = CNT_W'(1);
        res.count = CNT_W'(1);
        wide_idx = ADDR_W'(idx);
        res.top = base_addr + ((wide_idx + 1'b1) << PAGE_BITS);
      end
    end else if (act > ACT_SHARE_SUB) begin
      // Undefined action codes leave everything as it is.
    end else if (!in_pool) begin
      res.status = ST_RANGE;
    end else if (share_of[idx] == 0) begin
      res.status = ST_NOT_USED;
    end else begin
      case (act)
        ACT_FREE: begin
          share_of[idx]--;
          res.count = share_of[idx];
          if (res.count != 0) res.status = ST_SHARED;
          else return_page(idx, 1'b1, res.wake);
        end
        ACT_FORCE: begin
          share_of[idx] = '0;
          return_page(idx, 1'b0, res.wake);
        end
        ACT_SHARE_ADD: begin
          if (share_of[idx] != CNT_MAX) share_of[idx]++;
          res.count = share_of[idx];
        end
        default: begin
          // Share sub never takes the last reference.
          if (share_of[idx] > 1) share_of[idx]--;
          res.count = share_of[idx];
        end
      endcase
    end
    res.free_pages = pages_free;
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] seen);
    if (want !== seen) begin
      errors++;
      $error("%s: expected %0h, got %0h", field, want, seen);
    end
  endtask

  always @(posedge clk) begin : watch
    page_result_t want;
    if (rst) begin
      for (int i = 0; i < POOL_PAGES; i++) begin
        free_ring[i] = IDX_W'(i);
        share_of[i] = '0;
      end
      ring_front = '0;
      pages_free = FREE_W'(POOL_PAGES);
      waiters = '0;
      base_addr = '0;
      errors = 0;
      results_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write) base_addr = cfg_data;
      // The older result is checked before the new transfer is predicted.
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          errors++;
          $error("result transfer with no action outstanding");
        end else begin
          want = results_due.pop_front();
          check_field("status", 64'(want.status), 64'(m_axis_tuser));
          check_field("alloc_top", 64'(want.top), 64'(m_axis_tdata[ADDR_W-1:0]));
          check_field("share_count", 64'(want.count),
                      64'(m_axis_tdata[CNT_LO +: CNT_W]));
          check_field("free_pages", 64'(want.free_pages),
                      64'(m_axis_tdata[FREE_LO +: FREE_W]));
          check_field("wake_waiter", 64'(want.wake), 64'(m_axis_tdata[WAKE_AT]));
          check_field("tdata padding", '0, 64'(m_axis_tdata[OUT_TDATA_W-1:PAD_LO]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_page_action(s_axis_tuser, s_axis_tdata[ADDR_W-1:0], want);
        results_due.push_back(want);
      end
      outstanding <= results_due.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the page allocator test: clock, reset, pool base settings and action
// stimulus with random gaps and stalls; the checker module judges the results.
// Depends on rpa_pkg, refcounted_page_allocator and the checker.
module testbench;
  import rpa_pkg::*;

  localparam int POOL_PAGES     = 1024;
  localparam int PAGE_BITS      = 12;
  localparam int PAGE_BYTES     = 1 << PAGE_BITS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 240;
  localparam int MIX_MIXED      = 0;
  localparam int MIX_DRAIN      = 1;
  localparam int MIX_RELEASE    = 2;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    int               idx;
  } sent_action_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [ADDR_W-1:0]      cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [ACT_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]        m_axis_tuser;
  int                     errors;
  int                     outstanding;

  logic [ADDR_W-1:0] base = '0;
  sent_action_t      sent_actions [$];
  int                known_pages [$];
  int                empty_seen = 0;
  int                tx_calm = 0;
  int                rx_calm = 0;
  bit                hold_req = 1'b0;
  int                quiet_cycles = 0;

  always #5 clk = ~clk;

  refcounted_page_allocator #(
    .POOL_PAGES(POOL_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  refcounted_page_allocator_checker #(
    .POOL_PAGES(POOL_PAGES),
    .PAGE_BITS (PAGE_BITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .errors       (errors),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    if (rst || cfg_write || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Tracks which pages are in use so that most frees and share actions hit
  // live pages. This only steers the stimulus.
  always @(posedge clk) begin : track_pages
    sent_action_t      done;
    logic [ADDR_W-1:0] top;
    if (!rst && m_axis_tvalid && m_axis_tready && sent_actions.size() > 0) begin
      done = sent_actions.pop_front();
      top = m_axis_tdata[ADDR_W-1:0];
      if (m_axis_tuser == ST_EMPTY) empty_seen <= empty_seen + 1;
      if (done.act == ACT_ALLOC && m_axis_tuser == ST_OK) begin
        known_pages.push_back(int'(((top - base - PAGE_BYTES) >> PAGE_BITS) &
                                   (POOL_PAGES - 1)));
      end else if ((done.act == ACT_FREE || done.act == ACT_FORCE) &&
                   m_axis_tuser == ST_OK) begin
        for (int k = 0; k < known_pages.size(); k++) begin
          if (known_pages[k] == done.idx) begin
            known_pages.delete(k);
            break;
          end
        end
      end
    end
  end

  initial begin : receiver
    int stall;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (rx_calm > 0) begin
          stall = 0;
          rx_calm--;
        end else begin
          stall = $urandom_range(0, 4);
          if ($urandom_range(0, 39) == 0) rx_calm = 20;
        end
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
    end
  end

  function automatic logic [ADDR_W-1:0] page_addr(input int idx, input bit offset);
    logic [ADDR_W-1:0] wide_idx;
    wide_idx = ADDR_W'(idx);
    return base + (wide_idx << PAGE_BITS) +
           ADDR_W'(offset ? $urandom_range(0, PAGE_BYTES - 1) : 0);
  endfunction

  task automatic send_action(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr,
                             input int idx);
    int           gap;
    sent_action_t item;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 49) == 0) tx_calm = 25;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= addr;
    s_axis_tuser <= act;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    item.act = act;
    item.idx = idx;
    sent_actions.push_back(item);
  endtask

  task automatic random_action(input int mix);
    int                r;
    int                idx;
    int                c_alloc, c_free, c_force, c_add, c_sub;
    logic [ACT_W-1:0]  act;
    logic [ADDR_W-1:0] addr;
    case (mix)
      MIX_DRAIN: begin
        c_alloc = 92; c_free = 94; c_force = 95; c_add = 97; c_sub = 98;
      end
      MIX_RELEASE: begin
        c_alloc = 5; c_free = 40; c_force = 80; c_add = 85; c_sub = 90;
      end
      default: begin
        c_alloc = 30; c_free = 50; c_force = 60; c_add = 72; c_sub = 82;
      end
    endcase
    r = $urandom_range(0, 99);
    if (known_pages.size() > 0) idx = known_pages[$urandom_range(0, known_pages.size() - 1)];
    else idx = $urandom_range(0, POOL_PAGES - 1);
    addr = page_addr(idx, $urandom_range(0, 3) == 0);
    if (r < c_alloc) begin
      act = ACT_ALLOC;
      addr = ADDR_W'({$urandom, $urandom});
    end else if (r < c_free) begin
      act = ACT_FREE;
    end else if (r < c_force) begin
      act = ACT_FORCE;
    end else if (r < c_add) begin
      act = ACT_SHARE_ADD;
    end else if (r < c_sub) begin
      act = ACT_SHARE_SUB;
    end else begin
      // Noise: most likely free pages, wild addresses and undefined codes.
      act = ACT_W'($urandom_range(ACT_FREE, ACT_SHARE_SUB));
      case ($urandom_range(0, 2))
        0: begin
          idx = $urandom_range(0, POOL_PAGES - 1);
          addr = page_addr(idx, 1'b1);
        end
        1: addr = ADDR_W'({$urandom, $urandom});
        default: begin
          act = ACT_W'($urandom_range(int'(ACT_SHARE_SUB) + 1, (1 << ACT_W) - 1));
          addr = ADDR_W'({$urandom, $urandom});
        end
      endcase
    end
    send_action(act, addr, idx);
  endtask

  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    base = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : stimulus
    int                n;
    logic [ADDR_W-1:0] top_base;
    logic [ADDR_W-1:0] pool_end;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_base('0);
    pool_end = ADDR_W'(POOL_PAGES * PAGE_BYTES);

    send_action(ACT_ALLOC, '0, -1);
    send_action(ACT_ALLOC, '1, -1);
    send_action(ACT_SHARE_ADD, page_addr(0, 0), 0);
    // Low offset bits are ignored; the page stays shared after this free.
    send_action(ACT_FREE, page_addr(0, 0) | ADDR_W'(PAGE_BYTES - 1), 0);
    send_action(ACT_SHARE_SUB, page_addr(1, 0), 1);
    send_action(ACT_SHARE_ADD, page_addr(1, 0), 1);
    send_action(ACT_SHARE_SUB, page_addr(1, 0), 1);
    send_action(ACT_FREE, page_addr(0, 0), 0);
    send_action(ACT_ALLOC, '0, -1);
    send_action(ACT_FORCE, page_addr(1, 0), 1);
    send_action(ACT_FREE, page_addr(1, 0), 1);
    send_action(ACT_SHARE_ADD, page_addr(5, 0), 5);
    send_action(ACT_SHARE_SUB, page_addr(5, 0), 5);
    send_action(ACT_FORCE, page_addr(5, 0), 5);
    send_action(ACT_FREE, '1, -1);
    send_action(ACT_SHARE_ADD, pool_end, -1);
    send_action(ACT_SHARE_SUB, pool_end - 1, POOL_PAGES - 1);
    send_action(ACT_ALLOC, '1, -1);
    for (n = int'(ACT_SHARE_SUB) + 1; n < (1 << ACT_W); n++) begin
      send_action(ACT_W'(n), ADDR_W'({$urandom, $urandom}), -1);
    end
    wait_drained();

    // An all-ones base is unaligned; tops wrap around the address space.
    write_base('1);
    repeat (60) random_action(MIX_MIXED);
    wait_drained();

    top_base = ADDR_W'({$urandom, $urandom});
    top_base[PAGE_BITS-1:0] = '0;
    write_base(top_base);
    send_action(ACT_FREE, base - 1, -1);
    for (n = 0; n < 150; n++) begin
      if (n == 40) hold_req = 1'b1;
      if (n == 100) wait_drained();
      random_action(MIX_MIXED);
    end
    wait_drained();

    // The pool ends at the top of the address space, so the last top is zero.
    top_base = '0;
    write_base(top_base - pool_end);
    n = 0;
    while (empty_seen < 270 && n < 2500) begin
      random_action(MIX_DRAIN);
      n++;
    end
    repeat (100) random_action(MIX_RELEASE);
    wait_drained();
    repeat (8) @(posedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rpa_pkg.sv
hw/rtl/rpa_ram.sv
hw/rtl/rpa_ctrl.sv
hw/rtl/rpa_datapath.sv
hw/rtl/refcounted_page_allocator.sv
test/refcounted_page_allocator_checker.sv
test/testbench.sv
